FILE: sv/mbb_pkg.sv
// ----------------------------------------------------------------------------
// mbb_pkg
// Shared types and constants for the Bellman backup core.
// ----------------------------------------------------------------------------
package mbb_pkg;

	localparam int NUM_STATES     = 256;
	localparam int MAX_ACTIONS    = 8;
	localparam int MAX_SUCCESSORS = 8;

	localparam int SW = $clog2(NUM_STATES);
	localparam int AW = $clog2(MAX_ACTIONS);
	localparam int LW = $clog2(MAX_SUCCESSORS);

	localparam logic [3:0] UNEXPANDED = 4'd8;

	typedef enum logic [2:0] {
		CMD_COST   = 3'd0,
		CMD_SUCC   = 3'd1,
		CMD_VALUE  = 3'd2,
		CMD_UPDATE = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	typedef enum logic [0:0] {
		REG_NUM_ACTIONS = 1'b0,
		REG_NUM_SLOTS   = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_COST,
		ST_A_LOAD,
		ST_S_CHK,
		ST_S_MUL,
		ST_S_ADD,
		ST_A_END,
		ST_WB,
		ST_R_ISSUE,
		ST_R_DATA
	} state_t;

	typedef struct packed {
		logic capture;
		logic cost_rd;
		logic q_init;
		logic val_rd_succ;
		logic mul;
		logic q_add;
		logic act_end;
		logic wb;
		logic rd_issue;
		logic rd_out;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_stop;
		logic last_action;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: sv/mbb_ctrl.sv
// ----------------------------------------------------------------------------
// mbb_ctrl
// Sequencer for load, update and read beats.
// ----------------------------------------------------------------------------
module mbb_ctrl
	import mbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] cmd,
	output logic       in_ready,
	input  dp_sts_t    sts,
	output dp_cmd_t    dcmd
);

	state_t state_q, state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_UPDATE) state_d = ST_A_COST;
					else if (cmd == CMD_READ) state_d = ST_R_ISSUE;
				end
			end
			ST_A_COST:  state_d = ST_A_LOAD;
			ST_A_LOAD:  state_d = ST_S_CHK;
			ST_S_CHK:   state_d = sts.slot_stop ? ST_A_END : ST_S_MUL;
			ST_S_MUL:   state_d = ST_S_ADD;
			ST_S_ADD:   state_d = ST_S_CHK;
			ST_A_END:   state_d = sts.last_action ? ST_WB : ST_A_COST;
			ST_WB:      if (sts.out_free) state_d = ST_IDLE;
			ST_R_ISSUE: state_d = ST_R_DATA;
			ST_R_DATA:  if (sts.out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dcmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				dcmd.capture = in_valid;
			end
			ST_A_COST:  dcmd.cost_rd     = 1'b1;
			ST_A_LOAD:  dcmd.q_init      = 1'b1;
			ST_S_CHK:   dcmd.val_rd_succ = !sts.slot_stop;
			ST_S_MUL:   dcmd.mul         = 1'b1;
			ST_S_ADD:   dcmd.q_add       = 1'b1;
			ST_A_END:   dcmd.act_end     = 1'b1;
			ST_WB:      dcmd.wb          = sts.out_free;
			ST_R_ISSUE: dcmd.rd_issue    = 1'b1;
			ST_R_DATA:  dcmd.rd_out      = sts.out_free;
			default:    dcmd             = '0;
		endcase
	end

endmodule

FILE: sv/mbb_dp.sv
// ----------------------------------------------------------------------------
// mbb_dp
// Model tables, value and policy stores, accumulator and output register.
// ----------------------------------------------------------------------------
module mbb_dp
	import mbb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [3:0]         cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         cmd,
	input  logic [7:0]         state_index,
	input  logic [2:0]         action,
	input  logic [2:0]         slot,
	input  logic signed [8:0]  successor,
	input  logic [16:0]        probability,
	input  logic [31:0]        word_value,
	input  dp_cmd_t            dcmd,
	output dp_sts_t            sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        state_value,
	output logic [3:0]         best_action
);

	logic [31:0] cost_mem [NUM_STATES*MAX_ACTIONS];
	logic [25:0] succ_mem [NUM_STATES*MAX_ACTIONS*MAX_SUCCESSORS];
	logic [31:0] val_mem  [NUM_STATES];
	logic [AW-1:0] pol_mem [NUM_STATES];
	logic [NUM_STATES-1:0] pol_valid_q;

	logic [3:0]    num_actions_q, num_slots_q, na_c, ns_c;
	logic [SW-1:0] s_q;
	logic [AW-1:0] a_q, best_a_q;
	logic [LW:0]   i_q;
	logic [31:0]   q_q, best_q, cost_rdata_q, val_rdata_q;
	logic [25:0]   succ_rdata_q;
	logic [AW-1:0] pol_rdata_q;
	logic          polv_q;
	logic [48:0]   prod_s1;
	logic [33:0]   sum;
	logic          accept, val_rd, val_we;
	logic [SW-1:0] val_raddr, val_waddr;
	logic [31:0]   val_wdata;
	logic [LW-1:0] succ_slot;
	logic          succ_rd;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_actions_q <= 4'd8;
			num_slots_q   <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ACTIONS: num_actions_q <= cfg_wdata;
				REG_NUM_SLOTS:   num_slots_q   <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	always_comb begin
		if (num_actions_q == 4'd0) na_c = 4'd1;
		else if (num_actions_q > 4'(MAX_ACTIONS)) na_c = 4'(MAX_ACTIONS);
		else na_c = num_actions_q;
		if (num_slots_q == 4'd0) ns_c = 4'd1;
		else if (num_slots_q > 4'(MAX_SUCCESSORS)) ns_c = 4'(MAX_SUCCESSORS);
		else ns_c = num_slots_q;
	end

	// cost and successor tables: written by load beats
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_COST)
			cost_mem[{state_index, action}] <= word_value;
		if (accept && cmd == CMD_SUCC)
			succ_mem[{state_index, action, slot}] <= {successor, probability};
		if (dcmd.cost_rd)
			cost_rdata_q <= cost_mem[{s_q, a_q}];
		if (succ_rd)
			succ_rdata_q <= succ_mem[{s_q, a_q, succ_slot}];
	end

	assign succ_rd   = dcmd.cost_rd || dcmd.mul;
	assign succ_slot = dcmd.cost_rd ? '0 : LW'(i_q + 1'b1);

	// value store
	assign val_rd    = dcmd.val_rd_succ || dcmd.rd_issue;
	assign val_raddr = dcmd.val_rd_succ ? succ_rdata_q[24:17] : s_q;
	assign val_we    = dcmd.wb || (accept && cmd == CMD_VALUE);
	assign val_waddr = dcmd.wb ? s_q : state_index;
	assign val_wdata = dcmd.wb ? best_q : word_value;

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_waddr] <= val_wdata;
		if (val_rd) val_rdata_q <= val_mem[val_raddr];
		if (dcmd.wb) pol_mem[s_q] <= best_a_q;
		if (dcmd.rd_issue) pol_rdata_q <= pol_mem[s_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_valid_q <= '0;
			polv_q      <= 1'b0;
		end else begin
			if (dcmd.wb) pol_valid_q[s_q] <= 1'b1;
			if (dcmd.rd_issue) polv_q <= pol_valid_q[s_q];
		end
	end

	// backup datapath
	assign sum = {2'b00, q_q} + {1'b0, prod_s1[48:16]};

	always_ff @(posedge clk) begin
		if (dcmd.capture) begin
			s_q <= state_index;
			a_q <= '0;
		end
		if (dcmd.cost_rd) i_q <= '0;
		if (dcmd.q_init) q_q <= cost_rdata_q;
		if (dcmd.mul) prod_s1 <= val_rdata_q * succ_rdata_q[16:0];
		if (dcmd.q_add) begin
			q_q <= (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
			i_q <= i_q + 1'b1;
		end
		if (dcmd.act_end) begin
			if (a_q == '0 || q_q < best_q) begin
				best_q   <= q_q;
				best_a_q <= a_q;
			end
			a_q <= a_q + 1'b1;
		end
	end

	assign sts.slot_stop   = (i_q >= ns_c[LW:0]) || succ_rdata_q[25];
	assign sts.last_action = ({1'b0, a_q} + 4'd1) >= na_c;
	assign sts.out_free    = !out_valid || out_ready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (dcmd.wb || dcmd.rd_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.wb) begin
			state_value <= best_q;
			best_action <= {1'b0, best_a_q};
		end else if (dcmd.rd_out) begin
			state_value <= val_rdata_q;
			best_action <= polv_q ? {1'b0, pol_rdata_q} : UNEXPANDED;
		end
	end

endmodule

FILE: sv/mdp_bellman_backup_core.sv
// ----------------------------------------------------------------------------
// mdp_bellman_backup_core
// Bellman backup over a sparse cost-minimizing MDP model.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one beat per command. Cost,
// successor and value loads write their table in the accept cycle and give
// no result. A read fetches value and policy, then loads the result register.
// An update walks the actions in use; for each it reads the cost, loads the
// accumulator, then for each successor slot visited reads the successor's
// value through the single value-store read port, multiplies and accumulates;
// it then writes back the best value and action. One item is in flight at a
// time; in_ready is high only while the sequencer idles.
// Output channel (out_valid/out_ready) is a result register. A stalled
// receiver holds the result; a load beat can still be taken meanwhile, and
// a further update or read waits at its final step until the register frees.
// Reset clears the sequencer, the output register, the policy valid bits
// (every state reads back as action 8, unexpanded) and sets both count
// registers to 8. Tables are undefined until written; no clearing pass.
// Configuration is written through cfg_we/cfg_index/cfg_wdata by the user,
// only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module mdp_bellman_backup_core
	import mbb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [3:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [7:0]        state_index,
	input  logic [2:0]        action,
	input  logic [2:0]        slot,
	input  logic signed [8:0] successor,
	input  logic [16:0]       probability,
	input  logic [31:0]       word_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       state_value,
	output logic [3:0]        best_action
);

	dp_cmd_t dcmd;
	dp_sts_t sts;

	mbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.sts      (sts),
		.dcmd     (dcmd)
	);

	mbb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.state_index (state_index),
		.action      (action),
		.slot        (slot),
		.successor   (successor),
		.probability (probability),
		.word_value  (word_value),
		.dcmd        (dcmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.state_value (state_value),
		.best_action (best_action)
	);

endmodule

FILE: sv/mbb_checker.sv
// ----------------------------------------------------------------------------
// mbb_checker
// Port-level checks for the Bellman backup core.
// ----------------------------------------------------------------------------
module mbb_checker
	import mbb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  cmd,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] state_value,
	input logic [3:0]  best_action
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(state_value) && $stable(best_action))
		else $error("result beat changed while stalled");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_UPDATE || cmd == CMD_READ) |=> !in_ready)
		else $error("input taken while update or read in flight");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && (cmd == CMD_COST || cmd == CMD_SUCC ||
		cmd == CMD_VALUE) |=> !out_valid)
		else $error("load beat produced a result");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_action <= UNEXPANDED)
		else $error("best action out of range");

endmodule

bind mdp_bellman_backup_core mbb_checker u_mbb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.cmd         (cmd),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.state_value (state_value),
	.best_action (best_action)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for mdp_bellman_backup_core: loads costs,
// successor lists and values, runs updates and reads under random idling,
// back-pressure and several action/slot count settings, and compares each
// result beat against an in-bench backup predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import mbb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
	localparam int         STALL_LIMIT      = 5000;
	localparam int         DRAIN_CYCLES     = 250;

	typedef struct {
		logic [31:0] value;
		logic [3:0]  act;
	} backup_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	reg_idx_t          cfg_index = REG_NUM_ACTIONS;
	logic [3:0]        cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        cmd = CMD_READ;
	logic [7:0]        state_index = '0;
	logic [2:0]        action = '0;
	logic [2:0]        slot = '0;
	logic signed [8:0] successor = '0;
	logic [16:0]       probability = '0;
	logic [31:0]       word_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [31:0]       state_value;
	logic [3:0]        best_action;

	mdp_bellman_backup_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .state_index(state_index), .action(action), .slot(slot),
		.successor(successor), .probability(probability), .word_value(word_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.state_value(state_value), .best_action(best_action)
	);

	// predictor copy of the block
	logic [31:0] cost_mem [NUM_STATES*MAX_ACTIONS];
	logic [8:0]  succ_mem [NUM_STATES*MAX_ACTIONS*MAX_SUCCESSORS];
	logic [16:0] prob_mem [NUM_STATES*MAX_ACTIONS*MAX_SUCCESSORS];
	logic [31:0] value_mem [NUM_STATES];
	logic [3:0]  policy_mem [NUM_STATES];
	bit          cost_set [NUM_STATES*MAX_ACTIONS];
	bit          succ_set [NUM_STATES*MAX_ACTIONS*MAX_SUCCESSORS];
	bit          value_set [NUM_STATES];
	logic [3:0]  actions_reg = 4'd8;
	logic [3:0]  slots_reg = 4'd8;

	backup_result_t pending_results[$];
	int             mismatches = 0;
	int             beats_sent = 0;
	bit             no_idle = 1'b0;
	int             rx_hold = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int clamp_count(logic [3:0] v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void run_backup(int s);
		int          na;
		int          nsl;
		longint      q;
		longint      best_q;
		int          best;
		int          k;
		logic [8:0]  sp;
		na = clamp_count(actions_reg, MAX_ACTIONS);
		nsl = clamp_count(slots_reg, MAX_SUCCESSORS);
		best_q = 64'hFFFF_FFFF;
		best = 0;
		for (int a = 0; a < na; a++) begin
			q = cost_mem[s*MAX_ACTIONS + a];
			for (int i = 0; i < nsl; i++) begin
				k = (s*MAX_ACTIONS + a)*MAX_SUCCESSORS + i;
				sp = succ_mem[k];
				if (sp[8]) break;
				q += (longint'(value_mem[sp[7:0]]) * longint'(prob_mem[k])) >>> 16;
				if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
			end
			if (a == 0 || q < best_q) begin
				best_q = q;
				best = a;
			end
		end
		value_mem[s] = best_q[31:0];
		policy_mem[s] = best[3:0];
	endfunction

	function automatic void apply_beat(logic [2:0] c, logic [7:0] s, logic [2:0] a,
			logic [2:0] sl, logic [8:0] sp, logic [16:0] p, logic [31:0] w);
		int k;
		backup_result_t r;
		k = (s*MAX_ACTIONS + a)*MAX_SUCCESSORS + sl;
		case (c)
			CMD_COST: begin
				cost_mem[s*MAX_ACTIONS + a] = w;
				cost_set[s*MAX_ACTIONS + a] = 1'b1;
			end
			CMD_SUCC: begin
				succ_mem[k] = sp;
				prob_mem[k] = p;
				succ_set[k] = 1'b1;
			end
			CMD_VALUE: begin
				value_mem[s] = w;
				value_set[s] = 1'b1;
			end
			CMD_UPDATE, CMD_READ: begin
				if (c == CMD_UPDATE) begin
					run_backup(s);
					value_set[s] = 1'b1;
				end
				r.value = value_mem[s];
				r.act = policy_mem[s];
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 32'h000F_FFFF);
			default: return $urandom_range(0, 32'h000F_FFFF);
		endcase
	endfunction

	function automatic logic [16:0] rand_prob();
		if ($urandom_range(0, 7) == 0) return 17'($urandom_range(0, 131071));
		return 17'($urandom_range(0, 65536));
	endfunction

	function automatic logic [8:0] rand_succ();
		case ($urandom_range(0, 9))
			0: return 9'(256 + $urandom_range(0, 255));
			1: return 9'($urandom_range(0, 255));
			default: return 9'($urandom_range(0, 15));
		endcase
	endfunction

	task automatic send_beat(logic [2:0] c, logic [7:0] s, logic [2:0] a, logic [2:0] sl,
			logic [8:0] sp, logic [16:0] p, logic [31:0] w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		state_index <= s;
		action <= a;
		slot <= sl;
		successor <= sp;
		probability <= p;
		word_value <= w;
		do @(posedge clk); while (!in_ready);
		apply_beat(c, s, a, sl, sp, p, w);
		if (c <= CMD_READ) beats_sent++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drain();
		go_idle();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [3:0] val);
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NUM_ACTIONS) actions_reg = val;
		else slots_reg = val;
	endtask

	task automatic read_state(logic [7:0] s);
		if (!value_set[s]) send_beat(CMD_VALUE, s, 0, 0, 0, 0, rand_word());
		send_beat(CMD_READ, s, 3'($urandom), 3'($urandom), 9'($urandom),
				17'($urandom), $urandom);
	endtask

	// fill whatever the update will touch under the current counts, then update
	task automatic update_state(logic [7:0] s);
		int         na;
		int         nsl;
		int         k;
		logic [8:0] sp;
		na = clamp_count(actions_reg, MAX_ACTIONS);
		nsl = clamp_count(slots_reg, MAX_SUCCESSORS);
		for (int a = 0; a < na; a++) begin
			if (!cost_set[s*MAX_ACTIONS + a])
				send_beat(CMD_COST, s, 3'(a), 0, 0, 0, rand_word());
			for (int i = 0; i < nsl; i++) begin
				k = (s*MAX_ACTIONS + a)*MAX_SUCCESSORS + i;
				if (!succ_set[k])
					send_beat(CMD_SUCC, s, 3'(a), 3'(i), rand_succ(), rand_prob(), 0);
				sp = succ_mem[k];
				if (sp[8]) break;
				if (!value_set[sp[7:0]])
					send_beat(CMD_VALUE, sp[7:0], 0, 0, 0, 0, rand_word());
			end
		end
		send_beat(CMD_UPDATE, s, 3'($urandom), 3'($urandom), 9'($urandom),
				17'($urandom), $urandom);
	endtask

	function automatic logic [7:0] rand_state();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 15));
	endfunction

	task automatic random_beat();
		logic [7:0] s;
		s = rand_state();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8: update_state(s);
			9, 10, 11: read_state(s);
			12, 13: send_beat(CMD_COST, s, 3'($urandom), 0, 0, 0, rand_word());
			14, 15, 16: send_beat(CMD_SUCC, s, 3'($urandom), 3'($urandom), rand_succ(),
					rand_prob(), 0);
			17, 18: send_beat(CMD_VALUE, s, 0, 0, 0, 0, rand_word());
			default: send_beat(3'($urandom_range(CMD_FIRST_UNUSED, 7)), s, 3'($urandom),
					3'($urandom), 9'($urandom), 17'($urandom), $urandom);
		endcase
	endtask

	task automatic test_directed();
		send_beat(CMD_VALUE, 8'd255, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_beat(CMD_VALUE, 8'd0, 0, 0, 0, 0, 32'h0000_0000);
		read_state(8'd255);
		read_state(8'd0);
		for (int c = CMD_FIRST_UNUSED; c <= 7; c++)
			send_beat(3'(c), 8'd255, 3'd7, 3'd7, 9'h1FF, 17'h1FFFF, 32'hFFFF_FFFF);
		// all actions tie: lowest wins
		for (int a = 0; a < MAX_ACTIONS; a++) begin
			send_beat(CMD_COST, 8'd1, 3'(a), 0, 0, 0, 32'd5);
			send_beat(CMD_SUCC, 8'd1, 3'(a), 0, 9'h1FF, 17'd0, 0);
		end
		update_state(8'd1);
		// saturation through infinite successor and probability above one
		send_beat(CMD_COST, 8'd2, 3'd0, 0, 0, 0, 32'hFFFF_FFF0);
		send_beat(CMD_SUCC, 8'd2, 3'd0, 3'd0, 9'd255, 17'h1FFFF, 0);
		send_beat(CMD_COST, 8'd2, 3'd7, 0, 0, 0, 32'd0);
		send_beat(CMD_SUCC, 8'd2, 3'd7, 3'd0, 9'h100, 17'd65536, 0);
		update_state(8'd2);
		send_beat(CMD_SUCC, 8'd3, 3'd7, 3'd7, 9'd0, 17'd65536, 0);
		update_state(8'd3);
	endtask

	task automatic test_counts();
		logic [3:0] settings [6][2] = '{'{4'd1, 4'd1}, '{4'd8, 4'd8}, '{4'd0, 4'd15},
				'{4'd15, 4'd0}, '{4'd3, 4'd5}, '{4'd8, 4'd8}};
		int base;
		base = beats_sent;
		for (int i = 0; i < 6; i++) begin
			write_reg(REG_NUM_ACTIONS, settings[i][0]);
			write_reg(REG_NUM_SLOTS, settings[i][1]);
			while (beats_sent < base + 25*(i + 1)) random_beat();
		end
	endtask

	task automatic test_backpressure();
		rx_hold = 400;
		for (int i = 0; i < 6; i++) begin
			send_beat(CMD_VALUE, rand_state(), 0, 0, 0, 0, rand_word());
			update_state(rand_state());
		end
		wait_drain();
		repeat (20) random_beat();
	endtask

	task automatic test_random();
		int n;
		n = 0;
		while (beats_sent < 750) begin
			if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
			random_beat();
			n++;
		end
		no_idle = 1'b0;
	endtask

	// result side: per-beat random stall, long hold when asked
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		backup_result_t r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat value=%h action=%0d", $time,
						state_value, best_action);
				mismatches++;
			end else begin
				r = pending_results.pop_front();
				if (state_value !== r.value) begin
					$display("%0t: state_value expected %h actual %h", $time,
							r.value, state_value);
					mismatches++;
				end
				if (best_action !== r.act) begin
					$display("%0t: best_action expected %0d actual %0d", $time,
							r.act, best_action);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout", $time);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		for (int s = 0; s < NUM_STATES; s++) policy_mem[s] = UNEXPANDED;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_counts();
		test_backpressure();
		test_random();
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/mbb_pkg.sv
sv/mbb_ctrl.sv
sv/mbb_dp.sv
sv/mdp_bellman_backup_core.sv
sv/mbb_checker.sv
test/tb_top.sv
